// ----- rtl/hsv_pkg.sv -----
package hsv_pkg;

   // field widths of one pixel and one result
   localparam int ChanW = 8;
   localparam int HueW  = 15;
   localparam int SatW  = 13;

   // both divisors are twice an 8-bit level
   localparam int DenW = ChanW + 1;

   // hue sector picked by the largest channel (red, then green, then blue)
   typedef enum logic [1:0] {
      SEC_RED,
      SEC_RED_WRAP,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   // per-pixel data that rides along the divider stages
   typedef struct packed {
      logic             grey;
      logic             black;
      logic [ChanW-1:0] level;
   } side_type;

endpackage

// ----- rtl/rgb_to_hsv_core.sv -----
// RGB to HSV converter for 8-bit pixels, one pixel per clock while req_stall is low,
// no state between pixels. Hue comes out in degrees times 2^HUE_FRAC_BITS and
// saturation times 2^SAT_FRAC_BITS, both rounded to nearest with halves up; value is
// the largest channel level. Grey pixels give hue 0 and black pixels saturation 0. An
// accepted request beat passes two front stages, one divider stage per quotient bit,
// and the output register on its way to its response beat. The throughput of one beat
// per clock while req_stall is low is set by the two pipelined dividers running side
// by side. req_stall comes from a register: the output register and one skid entry
// hold results while rsp_stall is high, and req_stall rises only once both are full.
module rgb_to_hsv_core import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ChanW-1:0] req_red,
   input  logic [ChanW-1:0] req_green,
   input  logic [ChanW-1:0] req_blue,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [HueW-1:0]  rsp_hue_scaled,
   output logic [SatW-1:0]  rsp_saturation_scaled,
   output logic [ChanW-1:0] rsp_value_level
);

   // quotient widths: hue up to 360 * 2^frac, saturation up to 2^frac
   localparam int HueQuoW = 9 + HUE_FRAC_BITS;
   localparam int SatQuoW = SAT_FRAC_BITS + 1;
   localparam int QuoW    = (HueQuoW > SatQuoW) ? HueQuoW : SatQuoW;
   localparam int RemW    = DenW + QuoW;

   logic             adv;
   logic             fr_valid;
   logic [RemW-1:0]  fr_hnum, fr_snum;
   logic [DenW-1:0]  fr_hden, fr_sden;
   side_type         fr_side;
   logic             dv_valid;
   logic [QuoW-1:0]  dv_hquo, dv_squo;
   side_type         dv_side;

   assign req_stall = ~adv;

   // max, min, sector and dividends
   hsv_front #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .SAT_FRAC_BITS (SAT_FRAC_BITS),
      .REM_W         (RemW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (fr_valid),
      .hue_num   (fr_hnum),
      .hue_den   (fr_hden),
      .sat_num   (fr_snum),
      .sat_den   (fr_sden),
      .out_side  (fr_side)
   );

   // pipelined hue and saturation dividers
   hsv_div #(
      .QUO_W (QuoW),
      .REM_W (RemW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .hue_num   (fr_hnum),
      .hue_den   (fr_hden),
      .sat_num   (fr_snum),
      .sat_den   (fr_sden),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .hue_quo   (dv_hquo),
      .sat_quo   (dv_squo),
      .out_side  (dv_side)
   );

   // wrap, special cases and response buffering
   hsv_out #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .SAT_FRAC_BITS (SAT_FRAC_BITS),
      .QUO_W         (QuoW)
   ) u_out (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (dv_valid),
      .hue_quo               (dv_hquo),
      .sat_quo               (dv_squo),
      .in_side               (dv_side),
      .adv                   (adv),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hue_scaled        (rsp_hue_scaled),
      .rsp_saturation_scaled (rsp_saturation_scaled),
      .rsp_value_level       (rsp_value_level)
   );

endmodule

// ----- rtl/hsv_front.sv -----
module hsv_front import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12,
   parameter int REM_W         = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [ChanW-1:0] in_red,
   input  logic [ChanW-1:0] in_green,
   input  logic [ChanW-1:0] in_blue,
   output logic             out_valid,
   output logic [REM_W-1:0] hue_num,
   output logic [DenW-1:0]  hue_den,
   output logic [REM_W-1:0] sat_num,
   output logic [DenW-1:0]  sat_den,
   output side_type         out_side
);

   // stage 1: max, min, sector and channel difference
   logic             s1_valid_ff;
   logic [ChanW-1:0] s1_hi_ff, s1_hi_in;
   logic [ChanW-1:0] s1_delta_ff, s1_delta_in;
   sector_type       s1_sec_ff, s1_sec_in;
   logic signed [ChanW:0] s1_diff_ff, s1_diff_in;
   logic [ChanW-1:0] lo;

   always_comb begin
      s1_hi_in = in_red;
      lo       = in_red;
      if (in_green > s1_hi_in) s1_hi_in = in_green;
      if (in_blue > s1_hi_in) s1_hi_in = in_blue;
      if (in_green < lo) lo = in_green;
      if (in_blue < lo) lo = in_blue;
      s1_delta_in = s1_hi_in - lo;
      if (s1_hi_in == in_red) begin
         s1_sec_in  = (in_green < in_blue) ? SEC_RED_WRAP : SEC_RED;
         s1_diff_in = signed'({1'b0, in_green}) - signed'({1'b0, in_blue});
      end else if (s1_hi_in == in_green) begin
         s1_sec_in  = SEC_GREEN;
         s1_diff_in = signed'({1'b0, in_blue}) - signed'({1'b0, in_red});
      end else begin
         s1_sec_in  = SEC_BLUE;
         s1_diff_in = signed'({1'b0, in_red}) - signed'({1'b0, in_green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hi_ff    <= s1_hi_in;
         s1_delta_ff <= s1_delta_in;
         s1_sec_ff   <= s1_sec_in;
         s1_diff_ff  <= s1_diff_in;
      end
   end

   // stage 2: 60 * diff + offset * delta, then both dividends and divisors
   logic [16:0]        off_term;
   logic signed [17:0] diff_ext;
   logic signed [17:0] term60;
   logic signed [17:0] hue_base;

   always_comb begin
      unique case (s1_sec_ff)
         SEC_RED:      off_term = '0;
         SEC_RED_WRAP: off_term = 17'(s1_delta_ff) * 17'd360;
         SEC_GREEN:    off_term = 17'(s1_delta_ff) * 17'd120;
         SEC_BLUE:     off_term = 17'(s1_delta_ff) * 17'd240;
         default:      off_term = '0;
      endcase
      diff_ext = 18'(s1_diff_ff);
      term60   = diff_ext * 18'sd60;
      hue_base = term60 + signed'({1'b0, off_term});
   end

   logic             s2_valid_ff;
   logic [REM_W-1:0] s2_hnum_ff, s2_hnum_in;
   logic [DenW-1:0]  s2_hden_ff, s2_hden_in;
   logic [REM_W-1:0] s2_snum_ff, s2_snum_in;
   logic [DenW-1:0]  s2_sden_ff, s2_sden_in;
   side_type         s2_side_ff, s2_side_in;

   // rounding half up folded in: (2 * num + den) / (2 * den)
   always_comb begin
      s2_hnum_in       = (REM_W'(hue_base[16:0]) << (HUE_FRAC_BITS + 1))
                         + REM_W'(s1_delta_ff);
      s2_hden_in       = {s1_delta_ff, 1'b0};
      s2_snum_in       = (REM_W'(s1_delta_ff) << (SAT_FRAC_BITS + 1)) + REM_W'(s1_hi_ff);
      s2_sden_in       = {s1_hi_ff, 1'b0};
      s2_side_in.grey  = (s1_delta_ff == '0);
      s2_side_in.black = (s1_hi_ff == '0);
      s2_side_in.level = s1_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_hnum_ff <= s2_hnum_in;
         s2_hden_ff <= s2_hden_in;
         s2_snum_ff <= s2_snum_in;
         s2_sden_ff <= s2_sden_in;
         s2_side_ff <= s2_side_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign hue_num   = s2_hnum_ff;
   assign hue_den   = s2_hden_ff;
   assign sat_num   = s2_snum_ff;
   assign sat_den   = s2_sden_ff;
   assign out_side  = s2_side_ff;

endmodule

// ----- rtl/hsv_div.sv -----
module hsv_div import hsv_pkg::*; #(
   parameter int QUO_W = 15,
   parameter int REM_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [REM_W-1:0] hue_num,
   input  logic [DenW-1:0]  hue_den,
   input  logic [REM_W-1:0] sat_num,
   input  logic [DenW-1:0]  sat_den,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [QUO_W-1:0] hue_quo,
   output logic [QUO_W-1:0] sat_quo,
   output side_type         out_side
);

   // one quotient bit per stage for both divisions, msb first
   logic             vld_ff  [QUO_W];
   logic [REM_W-1:0] hrem_ff [QUO_W];
   logic [QUO_W-1:0] hquo_ff [QUO_W];
   logic [DenW-1:0]  hden_ff [QUO_W];
   logic [REM_W-1:0] srem_ff [QUO_W];
   logic [QUO_W-1:0] squo_ff [QUO_W];
   logic [DenW-1:0]  sden_ff [QUO_W];
   side_type         side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int Sh = QUO_W - 1 - k;

      logic             vld_prev;
      logic [REM_W-1:0] hrem_prev, srem_prev;
      logic [QUO_W-1:0] hquo_prev, squo_prev;
      logic [DenW-1:0]  hden_prev, sden_prev;
      side_type         side_prev;
      logic [REM_W-1:0] hcand, scand;
      logic             hge, sge;
      logic [REM_W-1:0] hrem_in, srem_in;
      logic [QUO_W-1:0] hquo_in, squo_in;

      // previous stage or the dividends themselves
      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign hrem_prev = hue_num;
         assign hquo_prev = '0;
         assign hden_prev = hue_den;
         assign srem_prev = sat_num;
         assign squo_prev = '0;
         assign sden_prev = sat_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign hrem_prev = hrem_ff[k-1];
         assign hquo_prev = hquo_ff[k-1];
         assign hden_prev = hden_ff[k-1];
         assign srem_prev = srem_ff[k-1];
         assign squo_prev = squo_ff[k-1];
         assign sden_prev = sden_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // restoring step against the shifted divisor
      always_comb begin
         hcand       = REM_W'(hden_prev) << Sh;
         scand       = REM_W'(sden_prev) << Sh;
         hge         = (hrem_prev >= hcand);
         sge         = (srem_prev >= scand);
         hrem_in     = hge ? (hrem_prev - hcand) : hrem_prev;
         srem_in     = sge ? (srem_prev - scand) : srem_prev;
         hquo_in     = hquo_prev;
         hquo_in[Sh] = hge;
         squo_in     = squo_prev;
         squo_in[Sh] = sge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            hrem_ff[k] <= hrem_in;
            hquo_ff[k] <= hquo_in;
            hden_ff[k] <= hden_prev;
            srem_ff[k] <= srem_in;
            squo_ff[k] <= squo_in;
            sden_ff[k] <= sden_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign hue_quo   = hquo_ff[QUO_W-1];
   assign sat_quo   = squo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ----- rtl/hsv_out.sv -----
module hsv_out import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12,
   parameter int QUO_W         = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [QUO_W-1:0] hue_quo,
   input  logic [QUO_W-1:0] sat_quo,
   input  side_type         in_side,
   output logic             adv,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [HueW-1:0]  rsp_hue_scaled,
   output logic [SatW-1:0]  rsp_saturation_scaled,
   output logic [ChanW-1:0] rsp_value_level
);

   localparam int FullTurnInt = 360 << HUE_FRAC_BITS;
   localparam int SatOneInt   = 1 << SAT_FRAC_BITS;
   localparam logic [QUO_W-1:0] FullTurn = QUO_W'(FullTurnInt);
   localparam logic [QUO_W-1:0] SatOne   = QUO_W'(SatOneInt);

   // wrap a full turn, force grey and black pixels, cut to field widths
   logic [QUO_W-1:0]      hue_val, sat_val;
   logic [HueW+QUO_W-1:0] hue_ext;
   logic [SatW+QUO_W-1:0] sat_ext;
   logic [HueW-1:0]       new_hue;
   logic [SatW-1:0]       new_sat;

   always_comb begin
      if (in_side.grey) begin
         hue_val = '0;
      end else if (hue_quo >= FullTurn) begin
         hue_val = hue_quo - FullTurn;
      end else begin
         hue_val = hue_quo;
      end
      sat_val = in_side.black ? '0 : sat_quo;
      hue_ext = {{HueW{1'b0}}, hue_val};
      sat_ext = {{SatW{1'b0}}, sat_val};
      new_hue = hue_ext[HueW-1:0];
      new_sat = sat_ext[SatW-1:0];
   end

   // output register plus skid entry; the pipeline moves while skid is empty
   logic             rsp_valid_ff, rsp_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [HueW-1:0]  rsp_hue_ff, skid_hue_ff;
   logic [SatW-1:0]  rsp_sat_ff, skid_sat_ff;
   logic [ChanW-1:0] rsp_lvl_ff, skid_lvl_ff;
   logic             out_take, incoming, load_out, load_skid, from_skid;

   assign adv      = ~skid_valid_ff;
   assign out_take = rsp_valid_ff & ~rsp_stall;
   assign incoming = adv & in_valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      from_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            load_out      = 1'b1;
            from_skid     = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (incoming) begin
         if (!rsp_valid_ff || out_take) begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_hue_ff <= from_skid ? skid_hue_ff : new_hue;
         rsp_sat_ff <= from_skid ? skid_sat_ff : new_sat;
         rsp_lvl_ff <= from_skid ? skid_lvl_ff : in_side.level;
      end
      if (load_skid) begin
         skid_hue_ff <= new_hue;
         skid_sat_ff <= new_sat;
         skid_lvl_ff <= in_side.level;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hue_scaled        = rsp_hue_ff;
   assign rsp_saturation_scaled = rsp_sat_ff;
   assign rsp_value_level       = rsp_lvl_ff;

   // skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output register");

   // a taken output frees the skid entry
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid entry not drained after output beat");

   // a beat arriving at an empty output shows up next cycle
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid && adv && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished beat lost at output");

   // hue stays below a full turn and saturation at most one
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (hue_val < FullTurn) && (sat_val <= SatOne))
      else $error("hue or saturation out of range");

endmodule

// ----- verif/rgb_to_hsv_core_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_hsv_core_tb import hsv_pkg::*;;

   localparam int HueFrac    = 6;
   localparam int SatFrac    = 12;
   localparam int CycleLimit = 200000;
   localparam int DrainWait  = 60;
   localparam int MaxReports = 10;

   // one expected conversion result
   typedef struct {
      logic [HueW-1:0]  hue;
      logic [SatW-1:0]  sat;
      logic [ChanW-1:0] val;
   } hsv_beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [ChanW-1:0] req_red = '0;
   logic [ChanW-1:0] req_green = '0;
   logic [ChanW-1:0] req_blue = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [HueW-1:0]  rsp_hue_scaled;
   logic [SatW-1:0]  rsp_saturation_scaled;
   logic [ChanW-1:0] rsp_value_level;

   hsv_beat_type pending_hsv[$];
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_cycles = 0;
   int        cycle_count = 0;
   int        pixels_sent = 0;
   int        results_seen = 0;
   int        mismatch_count = 0;
   int        stray_count = 0;

   rgb_to_hsv_core #(
      .HUE_FRAC_BITS(HueFrac),
      .SAT_FRAC_BITS(SatFrac)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hue_scaled        (rsp_hue_scaled),
      .rsp_saturation_scaled (rsp_saturation_scaled),
      .rsp_value_level       (rsp_value_level)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_hsv.size());
         $display("rgb_to_hsv_core verification failed");
         $finish;
      end
   end

   // fixed-point hsv of one pixel
   function automatic hsv_beat_type convert_pixel(input logic [ChanW-1:0] r,
                                                  input logic [ChanW-1:0] g,
                                                  input logic [ChanW-1:0] b);
      hsv_beat_type res;
      sector_type sec;
      int         hi;
      int         lo;
      int         delta;
      int         diff;
      int         offset;
      int         num;
      int         hue;
      int         sat;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      hue = 0;
      sat = 0;
      // sector order: red, then green, then blue
      if (hi == r) sec = (g < b) ? SEC_RED_WRAP : SEC_RED;
      else if (hi == g) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      if (delta != 0) begin
         case (sec)
            SEC_RED: begin
               diff = g - b;
               offset = 0;
            end
            SEC_RED_WRAP: begin
               diff = g - b;
               offset = 360;
            end
            SEC_GREEN: begin
               diff = b - r;
               offset = 120;
            end
            default: begin
               diff = r - g;
               offset = 240;
            end
         endcase
         num = 60 * (1 << HueFrac) * diff + offset * (1 << HueFrac) * delta;
         hue = (2 * num + delta) / (2 * delta);
         // a hue that rounds to a full turn wraps to zero
         if (hue >= 360 * (1 << HueFrac)) hue -= 360 * (1 << HueFrac);
      end
      if (hi != 0) sat = (2 * delta * (1 << SatFrac) + hi) / (2 * hi);
      res.hue = hue[HueW-1:0];
      res.sat = sat[SatW-1:0];
      res.val = hi[ChanW-1:0];
      return res;
   endfunction

   // offer one pixel beat, with a random idle gap ahead of it
   task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (req_stall);
      pending_hsv.push_back(convert_pixel(r, g, b));
      pixels_sent++;
   endtask

   // stop offering and wait until every result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   // random pixel, biased toward greys, ties and extremes
   task automatic send_random_pixel();
      logic [ChanW-1:0] r;
      logic [ChanW-1:0] g;
      logic [ChanW-1:0] b;
      r = ChanW'($urandom);
      g = ChanW'($urandom);
      b = ChanW'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            g = r;
            b = r;
         end
         1: begin
            if ($urandom_range(0, 1)) g = r;
            else b = ($urandom_range(0, 1)) ? r : g;
         end
         2: begin
            r = ChanW'($urandom_range(0, 3));
            g = ChanW'($urandom_range(0, 3));
            b = ChanW'($urandom_range(0, 3));
         end
         3: begin
            r = $urandom_range(0, 1) ? 8'hff : 8'h00;
            g = $urandom_range(0, 1) ? 8'hff : 8'h00;
            b = $urandom_range(0, 1) ? 8'hff : ChanW'($urandom_range(0, 255));
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // result check and receiver stall
   always @(posedge clock) begin
      hsv_beat_type exp_beat;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_hsv.size() == 0) begin
               stray_count++;
               if (mismatch_count + stray_count <= MaxReports)
                  $display("unexpected result beat: hue %0d sat %0d val %0d",
                           rsp_hue_scaled, rsp_saturation_scaled, rsp_value_level);
            end else begin
               exp_beat = pending_hsv.pop_front();
               if (rsp_hue_scaled !== exp_beat.hue || rsp_saturation_scaled !== exp_beat.sat ||
                   rsp_value_level !== exp_beat.val) begin
                  mismatch_count++;
                  if (mismatch_count + stray_count <= MaxReports)
                     $display("mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/act)",
                              exp_beat.hue, rsp_hue_scaled, exp_beat.sat,
                              rsp_saturation_scaled, exp_beat.val, rsp_value_level);
               end
            end
         end
         // long hold-off when asked, random stall otherwise
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // corners: black, white, greys, pure and mixed hues, wrap sector, channel extremes
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd200, 8'd10, 8'd100);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd254, 8'd253);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd3, 8'd1, 8'd2);
      send_pixel(8'haa, 8'h55, 8'haa);
      send_pixel(8'h55, 8'haa, 8'h55);
      send_pixel(8'd7, 8'd200, 8'd201);
      wait_drain();
   endtask

   // random pixels under one idle and stall mix
   task automatic test_random_phase(input int idle_pct, input int stall_p, input int count);
      send_idle_pct = idle_pct;
      stall_pct = stall_p;
      repeat (count) send_random_pixel();
      wait_drain();
   endtask

   // receiver holds off while the sender keeps offering, so the pipe fills
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 300;
      repeat (40) send_random_pixel();
      wait_drain();
   endtask

   // sender pauses mid-stream until everything has come back
   task automatic test_drain_pause();
      send_idle_pct = 10;
      stall_pct = 20;
      repeat (15) send_random_pixel();
      wait_drain();
      repeat (15) send_random_pixel();
      wait_drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 100);
      test_random_phase(59, 0, 100);
      test_random_phase(0, 59, 100);
      test_random_phase(31, 31, 100);
      test_backpressure();
      test_drain_pause();
      stall_pct = 0;
      repeat (DrainWait) @(posedge clock);
      $display("converted %0d pixels (%0d results checked) over corner, random, backpressure",
               pixels_sent, results_seen);
      $display("and drain phases; %0d mismatches, %0d stray beats, %0d left pending",
               mismatch_count, stray_count, pending_hsv.size());
      if (mismatch_count == 0 && stray_count == 0 && pending_hsv.size() == 0) begin
         $display("rgb_to_hsv_core verification clean");
      end else begin
         $display("rgb_to_hsv_core verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/hsv_pkg.sv
rtl/hsv_front.sv
rtl/hsv_div.sv
rtl/hsv_out.sv
rtl/rgb_to_hsv_core.sv
verif/rgb_to_hsv_core_tb.sv
